/* sv/qefs_pkg.sv */
package qefs_pkg;

   localparam int MAX_SEPARATORS_DEFAULT = 4;
   localparam int MAX_QUOTES_DEFAULT     = 4;
   localparam int LIST_SLOTS             = 4;
   localparam int QUEUE_DEPTH            = 4;
   localparam int CSR_INDEX_WIDTH        = 3;
   localparam int CSR_DATA_WIDTH         = 32;

   localparam logic [1:0] KIND_BYTE         = 2'd0;
   localparam logic [1:0] KIND_BREAK        = 2'd1;
   localparam logic [1:0] KIND_END          = 2'd2;
   localparam logic [1:0] KIND_END_UNCLOSED = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEPARATOR_CHARS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEPARATOR_COUNT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUOTE_CHARS     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUOTE_COUNT     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE_CHAR     = 3'd4;

   localparam logic [31:0] SEPARATOR_CHARS_RESET = 32'd44;
   localparam logic [2:0]  SEPARATOR_COUNT_RESET = 3'd1;
   localparam logic [31:0] QUOTE_CHARS_RESET     = 32'd10018;
   localparam logic [2:0]  QUOTE_COUNT_RESET     = 3'd2;
   localparam logic [7:0]  ESCAPE_CHAR_RESET     = 8'd92;

   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_END  = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // One accepted request worth of results: one or two beats.
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } entry_type;

endpackage

/* sv/qefs_front.sv */
module qefs_front #(
   parameter int MAX_SEPARATORS = qefs_pkg::MAX_SEPARATORS_DEFAULT,
   parameter int MAX_QUOTES     = qefs_pkg::MAX_QUOTES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  qefs_pkg::req_type                      req_data,
   input  logic                                   csr_we,
   input  logic [qefs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [qefs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output qefs_pkg::entry_type                    push_data
);

   logic [31:0] sep_chars_ff, sep_chars_in;
   logic [2:0]  sep_count_ff, sep_count_in;
   logic [31:0] quote_chars_ff, quote_chars_in;
   logic [2:0]  quote_count_ff, quote_count_in;
   logic [7:0]  esc_char_ff, esc_char_in;

   logic        esc_pending_ff, esc_pending_in;
   logic        quote_open_ff, quote_open_in;
   logic [7:0]  open_quote_ff, open_quote_in;

   logic        accept;
   logic        is_sep;
   logic        is_quote;
   logic        has_result;
   logic [7:0]  c;

   assign req_ready = push_ready;
   assign accept    = req_valid & req_ready;
   assign c         = req_data.data_byte;

   // Compare against every enabled list slot in parallel.
   always_comb begin
      is_sep   = 1'b0;
      is_quote = 1'b0;
      for (int i = 0; i < qefs_pkg::LIST_SLOTS; i++) begin
         if (i < MAX_SEPARATORS && 3'(i) < sep_count_ff && sep_chars_ff[8*i +: 8] == c) begin
            is_sep = 1'b1;
         end
         if (i < MAX_QUOTES && 3'(i) < quote_count_ff && quote_chars_ff[8*i +: 8] == c) begin
            is_quote = 1'b1;
         end
      end
   end

   always_comb begin
      esc_pending_in = esc_pending_ff;
      quote_open_in  = quote_open_ff;
      open_quote_in  = open_quote_ff;
      has_result     = 1'b0;
      push_data      = '0;
      if (req_data.mode == qefs_pkg::MODE_END) begin
         has_result     = 1'b1;
         esc_pending_in = 1'b0;
         quote_open_in  = 1'b0;
         open_quote_in  = 8'd0;
         if (esc_pending_ff) begin
            push_data.two              = 1'b1;
            push_data.first.out_kind   = qefs_pkg::KIND_BYTE;
            push_data.first.out_byte   = esc_char_ff;
            push_data.second.out_kind  = quote_open_ff ? qefs_pkg::KIND_END_UNCLOSED
                                                       : qefs_pkg::KIND_END;
            push_data.second.last_of_run = 1'b1;
         end else begin
            push_data.first.out_kind    = quote_open_ff ? qefs_pkg::KIND_END_UNCLOSED
                                                        : qefs_pkg::KIND_END;
            push_data.first.last_of_run = 1'b1;
         end
      end else if (esc_pending_ff) begin
         has_result     = 1'b1;
         esc_pending_in = 1'b0;
         if (!(c == esc_char_ff || is_sep || is_quote)) begin
            // Unknown escape: keep both bytes.
            push_data.two                = 1'b1;
            push_data.first.out_kind     = qefs_pkg::KIND_BYTE;
            push_data.first.out_byte     = esc_char_ff;
            push_data.second.out_kind    = qefs_pkg::KIND_BYTE;
            push_data.second.out_byte    = c;
            push_data.second.last_of_run = 1'b1;
         end else begin
            push_data.first.out_kind    = qefs_pkg::KIND_BYTE;
            push_data.first.out_byte    = c;
            push_data.first.last_of_run = 1'b1;
         end
      end else if (c == esc_char_ff) begin
         esc_pending_in = 1'b1;
      end else if (quote_open_ff && c == open_quote_ff) begin
         quote_open_in = 1'b0;
         open_quote_in = 8'd0;
      end else if (!quote_open_ff && is_quote) begin
         quote_open_in = 1'b1;
         open_quote_in = c;
      end else if (!quote_open_ff && is_sep) begin
         has_result                  = 1'b1;
         push_data.first.out_kind    = qefs_pkg::KIND_BREAK;
         push_data.first.last_of_run = 1'b1;
      end else begin
         has_result                  = 1'b1;
         push_data.first.out_kind    = qefs_pkg::KIND_BYTE;
         push_data.first.out_byte    = c;
         push_data.first.last_of_run = 1'b1;
      end
   end

   assign push_valid = accept & has_result;

   always_comb begin
      sep_chars_in   = sep_chars_ff;
      sep_count_in   = sep_count_ff;
      quote_chars_in = quote_chars_ff;
      quote_count_in = quote_count_ff;
      esc_char_in    = esc_char_ff;
      if (csr_we) begin
         case (csr_index)
            qefs_pkg::CSR_SEPARATOR_CHARS: sep_chars_in   = csr_wdata;
            qefs_pkg::CSR_SEPARATOR_COUNT: sep_count_in   = csr_wdata[2:0];
            qefs_pkg::CSR_QUOTE_CHARS:     quote_chars_in = csr_wdata;
            qefs_pkg::CSR_QUOTE_COUNT:     quote_count_in = csr_wdata[2:0];
            qefs_pkg::CSR_ESCAPE_CHAR:     esc_char_in    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_chars_ff   <= qefs_pkg::SEPARATOR_CHARS_RESET;
         sep_count_ff   <= qefs_pkg::SEPARATOR_COUNT_RESET;
         quote_chars_ff <= qefs_pkg::QUOTE_CHARS_RESET;
         quote_count_ff <= qefs_pkg::QUOTE_COUNT_RESET;
         esc_char_ff    <= qefs_pkg::ESCAPE_CHAR_RESET;
         esc_pending_ff <= 1'b0;
         quote_open_ff  <= 1'b0;
         open_quote_ff  <= 8'd0;
      end else begin
         sep_chars_ff   <= sep_chars_in;
         sep_count_ff   <= sep_count_in;
         quote_chars_ff <= quote_chars_in;
         quote_count_ff <= quote_count_in;
         esc_char_ff    <= esc_char_in;
         if (accept) begin
            esc_pending_ff <= esc_pending_in;
            quote_open_ff  <= quote_open_in;
            open_quote_ff  <= open_quote_in;
         end
      end
   end

endmodule

/* sv/qefs_queue.sv */
module qefs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  qefs_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output qefs_pkg::entry_type pop_data
);

   localparam int Depth  = qefs_pkg::QUEUE_DEPTH;
   localparam int PtrW   = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);

   qefs_pkg::entry_type slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != CountW'(Depth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/qefs_back.sv */
module qefs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  qefs_pkg::entry_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qefs_pkg::rsp_type   rsp_data
);

   qefs_pkg::rsp_type out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   qefs_pkg::rsp_type second_ff, second_in;
   logic              second_valid_ff, second_valid_in;
   logic              can_load;

   assign can_load  = !out_valid_ff || rsp_ready;
   assign pop_ready = can_load && !second_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_in          = out_ff;
      out_valid_in    = out_valid_ff;
      second_in       = second_ff;
      second_valid_in = second_valid_ff;
      if (can_load) begin
         if (second_valid_ff) begin
            // Drain the held second beat before the next request.
            out_in          = second_ff;
            out_valid_in    = 1'b1;
            second_valid_in = 1'b0;
         end else if (pop_valid) begin
            out_in          = pop_data.first;
            out_valid_in    = 1'b1;
            second_in       = pop_data.second;
            second_valid_in = pop_data.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         out_valid_ff    <= out_valid_in;
         second_valid_ff <= second_valid_in;
      end
      out_ff    <= out_in;
      second_ff <= second_in;
   end

endmodule

/* sv/quote_escape_field_splitter_top.sv */
// Escaped, quoted field splitter.
// Request channel (req_valid/req_ready/req_data) takes one byte per request,
// or an end-of-string request (mode set) that closes the string.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns field bytes, field
// breaks and one end mark per string; last_of_run flags the final response
// of each request. A request may produce zero, one or two responses.
// Configuration registers are written through csr_we/csr_index/csr_wdata
// only while the block is idle; the user is bound to this, and the block
// itself does not enforce it. Writes take effect on the next cycle.
// A request's first response passes through a queue slot, written when the
// request is accepted, and then through the output register. Throughput: one
// request per cycle while the queue has room; a request with two responses is
// limited by the single output register of the back end.
// A four-entry queue between classifier and output absorbs stalls: when
// rsp_ready is low, requests keep being taken until the queue fills, then
// req_ready drops. Requests that give no response never enter the queue.
// Synchronous reset restores the default separator, quotes and escape and
// clears escape and quote state and all queued responses.
module quote_escape_field_splitter_top #(
   parameter int MAX_SEPARATORS = qefs_pkg::MAX_SEPARATORS_DEFAULT,
   parameter int MAX_QUOTES     = qefs_pkg::MAX_QUOTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  qefs_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output qefs_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [qefs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qefs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                push_valid;
   logic                push_ready;
   qefs_pkg::entry_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   qefs_pkg::entry_type pop_data;

   qefs_front #(
      .MAX_SEPARATORS(MAX_SEPARATORS),
      .MAX_QUOTES    (MAX_QUOTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   qefs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   qefs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data (pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

/* bench/tb_quote_escape_field_splitter_top.sv */
module tb_quote_escape_field_splitter_top;

   localparam int SEP_LIMIT =
      (qefs_pkg::MAX_SEPARATORS_DEFAULT < qefs_pkg::LIST_SLOTS) ?
      qefs_pkg::MAX_SEPARATORS_DEFAULT : qefs_pkg::LIST_SLOTS;
   localparam int QUOTE_LIMIT =
      (qefs_pkg::MAX_QUOTES_DEFAULT < qefs_pkg::LIST_SLOTS) ?
      qefs_pkg::MAX_QUOTES_DEFAULT : qefs_pkg::LIST_SLOTS;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 92;
   localparam int SETTLE_CYCLES   = 8;
   localparam int LONG_HOLD       = 60;
   localparam int NUM_ROWS        = 23;

   typedef struct {
      qefs_pkg::req_type request;
      bit                typed;
      int                count;
      qefs_pkg::rsp_type first;
      qefs_pkg::rsp_type second;
   } dir_row_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   qefs_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   qefs_pkg::rsp_type rsp_data;
   logic              csr_we    = 1'b0;
   logic [qefs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [qefs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // shadow copy of the block's registers and string state
   logic [31:0] sep_chars   = qefs_pkg::SEPARATOR_CHARS_RESET;
   logic [2:0]  sep_count   = qefs_pkg::SEPARATOR_COUNT_RESET;
   logic [31:0] quote_chars = qefs_pkg::QUOTE_CHARS_RESET;
   logic [2:0]  quote_count = qefs_pkg::QUOTE_COUNT_RESET;
   logic [7:0]  esc_char    = qefs_pkg::ESCAPE_CHAR_RESET;
   bit          escape_pending = 1'b0;
   bit          quote_open     = 1'b0;
   logic [7:0]  open_quote     = 8'h00;

   // typed expectation travelling with the request being offered
   bit                row_typed  = 1'b0;
   int                row_count  = 0;
   qefs_pkg::rsp_type row_first  = '0;
   qefs_pkg::rsp_type row_second = '0;

   qefs_pkg::rsp_type expected_tokens[$];
   int      requests_taken = 0;
   int      tokens_seen    = 0;
   int      items_sent     = 0;
   int      failures       = 0;
   bit      steady         = 1'b0;
   bit      long_hold_req  = 1'b0;
   int      hold_left      = 0;

   // defaults: separator 2C, quotes 22 and 27, escape 5C
   dir_row_type dir_rows [NUM_ROWS] = '{
      '{'{qefs_pkg::MODE_END,  8'h00}, 1'b1, 1,
        '{qefs_pkg::KIND_END,  8'h00, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h61}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'h61, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h2C}, 1'b1, 1,
        '{qefs_pkg::KIND_BREAK, 8'h00, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h00}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'h00, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'hFF}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'hFF, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h22}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h2C}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'h2C, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h27}, 1'b0, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h22}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h5C}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h2C}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'h2C, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h5C}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h6E}, 1'b1, 2,
        '{qefs_pkg::KIND_BYTE, 8'h5C, 1'b0},
        '{qefs_pkg::KIND_BYTE, 8'h6E, 1'b1}},
      '{'{qefs_pkg::MODE_CHAR, 8'h5C}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h5C}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'h5C, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h5C}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_END,  8'h00}, 1'b1, 2,
        '{qefs_pkg::KIND_BYTE, 8'h5C, 1'b0},
        '{qefs_pkg::KIND_END, 8'h00, 1'b1}},
      '{'{qefs_pkg::MODE_CHAR, 8'h27}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h78}, 1'b0, 0, '0, '0},
      '{'{qefs_pkg::MODE_END,  8'hFF}, 1'b1, 1,
        '{qefs_pkg::KIND_END_UNCLOSED, 8'h00, 1'b1}, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h5C}, 1'b1, 0, '0, '0},
      '{'{qefs_pkg::MODE_CHAR, 8'h22}, 1'b1, 1,
        '{qefs_pkg::KIND_BYTE, 8'h22, 1'b1}, '0},
      '{'{qefs_pkg::MODE_END,  8'hAA}, 1'b1, 1,
        '{qefs_pkg::KIND_END, 8'h00, 1'b1}, '0}
   };

   quote_escape_field_splitter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic bit in_list(logic [7:0] c, logic [31:0] chars, logic [2:0] count,
                                  int limit);
      int n;
      bit hit;
      n = int'(count);
      if (n > limit) n = limit;
      hit = 1'b0;
      for (int i = 0; i < n; i++)
         if (chars[8*i +: 8] == c) hit = 1'b1;
      return hit;
   endfunction

   function automatic qefs_pkg::rsp_type make_token(logic [1:0] kind, logic [7:0] value);
      qefs_pkg::rsp_type t;
      t.out_kind    = kind;
      t.out_byte    = value;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   // append one token to the tail of the expected list
   task automatic queue_token(input qefs_pkg::rsp_type t);
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   // advance the string state by one request and queue the tokens it yields
   task automatic split_step(input qefs_pkg::req_type r, input bit record);
      qefs_pkg::rsp_type tokens [2];
      int                n;
      bit                is_sep;
      bit                is_quote;
      logic [7:0]        c;
      n = 0;
      c = r.data_byte;
      is_sep   = in_list(c, sep_chars, sep_count, SEP_LIMIT);
      is_quote = in_list(c, quote_chars, quote_count, QUOTE_LIMIT);
      if (r.mode == qefs_pkg::MODE_END) begin
         if (escape_pending) begin
            tokens[n] = make_token(qefs_pkg::KIND_BYTE, esc_char);
            n++;
         end
         tokens[n] = make_token(quote_open ? qefs_pkg::KIND_END_UNCLOSED
                                           : qefs_pkg::KIND_END, 8'h00);
         n++;
         escape_pending = 1'b0;
         quote_open     = 1'b0;
         open_quote     = 8'h00;
      end else if (escape_pending) begin
         escape_pending = 1'b0;
         if (!(c == esc_char || is_sep || is_quote)) begin
            tokens[n] = make_token(qefs_pkg::KIND_BYTE, esc_char);
            n++;
         end
         tokens[n] = make_token(qefs_pkg::KIND_BYTE, c);
         n++;
      end else if (c == esc_char) begin
         escape_pending = 1'b1;
      end else if (quote_open && c == open_quote) begin
         quote_open = 1'b0;
         open_quote = 8'h00;
      end else if (!quote_open && is_quote) begin
         quote_open = 1'b1;
         open_quote = c;
      end else if (!quote_open && is_sep) begin
         tokens[n] = make_token(qefs_pkg::KIND_BREAK, 8'h00);
         n++;
      end else begin
         tokens[n] = make_token(qefs_pkg::KIND_BYTE, c);
         n++;
      end
      if (n > 0) tokens[n-1].last_of_run = 1'b1;
      if (record)
         for (int i = 0; i < n; i++) queue_token(tokens[i]);
   endtask

   task automatic report_failure(input string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin : monitor
      qefs_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            requests_taken++;
            // typed rows still advance the predictor state
            split_step(req_data, !row_typed);
            if (row_typed) begin
               if (row_count > 0) queue_token(row_first);
               if (row_count > 1) queue_token(row_second);
            end
         end
         if (rsp_valid && rsp_ready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               report_failure($sformatf(
                  "response %0d with none expected: kind %0d byte %02h last %0d",
                  tokens_seen, rsp_data.out_kind, rsp_data.out_byte,
                  rsp_data.last_of_run));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.out_kind !== want.out_kind || rsp_data.out_byte !== want.out_byte ||
                   rsp_data.last_of_run !== want.last_of_run)
                  report_failure($sformatf({"response %0d: expected kind %0d byte %02h ",
                     "last %0d, got kind %0d byte %02h last %0d"},
                     tokens_seen, want.out_kind, want.out_byte, want.last_of_run,
                     rsp_data.out_kind, rsp_data.out_byte, rsp_data.last_of_run));
            end
         end
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   initial begin : receiver
      int idle_left;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ready = 1'b0;
         end else if (!steady && $urandom_range(0, 4) == 0) begin
            idle_left = $urandom_range(1, 6) - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input qefs_pkg::req_type r, input bit typed, input int count,
                               input qefs_pkg::rsp_type first,
                               input qefs_pkg::rsp_type second);
      if (!steady && hold_left == 0 && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_data   = r;
      row_typed  = typed;
      row_count  = count;
      row_first  = first;
      row_second = second;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input qefs_pkg::req_type r);
      send_request(r, 1'b0, 0, '0, '0);
   endtask

   function automatic qefs_pkg::req_type char_req(logic [7:0] value);
      qefs_pkg::req_type r;
      r.mode      = qefs_pkg::MODE_CHAR;
      r.data_byte = value;
      return r;
   endfunction

   function automatic qefs_pkg::req_type end_req();
      qefs_pkg::req_type r;
      r.mode      = qefs_pkg::MODE_END;
      r.data_byte = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic logic [7:0] sep_byte();
      int slot;
      slot = $urandom_range(0, 3);
      return sep_chars[8*slot +: 8];
   endfunction

   function automatic logic [7:0] quote_byte();
      int slot;
      slot = $urandom_range(0, 3);
      return quote_chars[8*slot +: 8];
   endfunction

   // random byte leaning toward the configured special bytes
   function automatic logic [7:0] any_byte();
      int pick;
      pick = $urandom_range(0, 4);
      case (pick)
         0: return sep_byte();
         1: return quote_byte();
         2: return esc_char;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one string built from plain, separator, escape and quoted segments
   task automatic send_string();
      int         segs;
      int         len;
      logic [7:0] q;
      segs = $urandom_range(0, 5);
      repeat (segs) begin
         case ($urandom_range(0, 3))
            0: send_plain(char_req(8'($urandom_range(0, 255))));
            1: send_plain(char_req(sep_byte()));
            2: begin
               send_plain(char_req(esc_char));
               send_plain(char_req(any_byte()));
            end
            default: begin
               q = quote_byte();
               send_plain(char_req(q));
               len = $urandom_range(0, 4);
               repeat (len) send_plain(char_req(any_byte()));
               if ($urandom_range(0, 9) != 0) send_plain(char_req(q));
            end
         endcase
      end
      send_plain(end_req());
   endtask

   // drop valid, wait out every queued token and the pipeline behind it
   task automatic settle_block();
      req_valid = 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [qefs_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [qefs_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         qefs_pkg::CSR_SEPARATOR_CHARS: sep_chars   = value;
         qefs_pkg::CSR_SEPARATOR_COUNT: sep_count   = value[2:0];
         qefs_pkg::CSR_QUOTE_CHARS:     quote_chars = value;
         qefs_pkg::CSR_QUOTE_COUNT:     quote_count = value[2:0];
         qefs_pkg::CSR_ESCAPE_CHAR:     esc_char    = value[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input int phase);
      logic [31:0] sc;
      logic [31:0] sn;
      logic [31:0] qc;
      logic [31:0] qn;
      logic [31:0] ec;
      sc = $urandom;
      qc = $urandom;
      ec = {24'h0, 8'($urandom_range(0, 255))};
      sn = $urandom_range(0, 7);
      qn = $urandom_range(0, 7);
      case (phase)
         1: begin
            // empty lists match nothing
            sn = 0;
            qn = 0;
         end
         2: begin
            // clamped counts, zero bytes inside the lists
            sc = {8'h00, sc[23:16], 8'h00, sc[7:0]};
            qc = {qc[31:24], 8'h00, qc[15:8], 8'h00};
            sn = 7;
            qn = 5;
         end
         3: begin
            sc = 32'hFFFF_FFFF;
            qc = 32'hFFFF_FFFF;
            sn = 4;
            qn = 4;
            ec = 32'h0000_00FF;
         end
         4: begin
            sc = 32'h0;
            qc = 32'h0;
            sn = 4;
            qn = 4;
            ec = 32'h0;
         end
         NUM_PHASES - 1: begin
            sc = qefs_pkg::SEPARATOR_CHARS_RESET;
            qc = qefs_pkg::QUOTE_CHARS_RESET;
            sn = 32'(qefs_pkg::SEPARATOR_COUNT_RESET);
            qn = 32'(qefs_pkg::QUOTE_COUNT_RESET);
            ec = 32'(qefs_pkg::ESCAPE_CHAR_RESET);
         end
         default: ;
      endcase
      write_csr(qefs_pkg::CSR_SEPARATOR_CHARS, sc);
      write_csr(qefs_pkg::CSR_SEPARATOR_COUNT, sn);
      write_csr(qefs_pkg::CSR_QUOTE_CHARS, qc);
      write_csr(qefs_pkg::CSR_QUOTE_COUNT, qn);
      write_csr(qefs_pkg::CSR_ESCAPE_CHAR, ec);
      csr_we = 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                phase_end;
      qefs_pkg::req_type noise;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].request, dir_rows[i].typed, dir_rows[i].count,
                      dir_rows[i].first, dir_rows[i].second);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            settle_block();
            apply_setting(phase);
         end
         if (phase == NUM_PHASES - 1) steady = 1'b1;
         // fill the block while the output is held off
         if (phase == 2) long_hold_req = 1'b1;
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 85) begin
               send_string();
            end else begin
               noise = ($urandom_range(0, 7) == 0) ? end_req() : char_req(any_byte());
               send_plain(noise);
            end
         end
      end

      settle_block();
      if (expected_tokens.size() != 0)
         report_failure($sformatf("%0d responses never arrived", expected_tokens.size()));

      $display("summary: %0d requests, %0d responses, %0d register settings",
               requests_taken, tokens_seen, NUM_PHASES);
      $display({"summary: escapes, quoted runs, unclosed quotes, clamped and empty lists, ",
                "%0d-cycle stall"}, LONG_HOLD);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d failures", failures);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
sv/qefs_pkg.sv
sv/qefs_front.sv
sv/qefs_queue.sv
sv/qefs_back.sv
sv/quote_escape_field_splitter_top.sv
bench/tb_quote_escape_field_splitter_top.sv
